// ===== rtl/etwfa_pkg.sv =====
package etwfa_pkg;

  // Frame geometry.
  localparam int FRAME_WIDTH  = 768;
  localparam int FRAME_HEIGHT = 608;
  localparam int PIX_COUNT    = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W       = $clog2(PIX_COUNT);
  localparam int TAG_W        = 32;

  // Pixel codes as reported.
  localparam logic [7:0] PIX_POS   = 8'd255;
  localparam logic [7:0] PIX_NEG   = 8'd128;
  localparam logic [7:0] PIX_EMPTY = 8'd0;

  // Register defaults and scaling.
  localparam logic [9:0]  US_PER_MS        = 10'd1000;
  localparam logic [15:0] WINDOW_MS_RESET  = 16'd33;
  localparam logic [22:0] MAX_EVENTS_RESET = 23'd5000000;
  localparam int          SIZE_US_W        = 26;

  // Register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_EVENTS  = 1'b1;

  typedef enum logic [1:0] {
    OP_EVENT = 2'd0,
    OP_TICK  = 2'd1,
    OP_FORCE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  // Report of a window close, produced by the control unit.
  typedef struct packed {
    logic              closed;
    logic [31:0]       id;
    logic [63:0]       start_us;
    logic [63:0]       end_us;
    logic [22:0]       events;
  } close_info_t;

  // Frame store entry: the window id it was painted in and its polarity.
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic              pos;
  } pix_entry_t;

  // Write request to the frame store.
  typedef struct packed {
    logic              we;
    logic              bank;
    logic [ADDR_W-1:0] addr;
    pix_entry_t        entry;
  } pix_wr_t;

  // Read request to the frame store.
  typedef struct packed {
    logic              re;
    logic              bank;
    logic [ADDR_W-1:0] addr;
  } pix_rd_t;

endpackage

// ===== rtl/etwfa_frame_mem.sv =====
module etwfa_frame_mem
  import etwfa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pix_wr_t    wr_i,
  input  pix_rd_t    rd_i,
  output pix_entry_t rdata_o,
  output logic       busy_o
);

  // Two banks, one for even and one for odd window ids. An entry counts only
  // when its tag equals the window id expected, so no copy or clear is needed
  // on a window close.
  pix_entry_t bank0_mem [PIX_COUNT];
  pix_entry_t bank1_mem [PIX_COUNT];

  logic              clr_busy_q, clr_busy_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  pix_entry_t        rdata_q;

  // Clearing pass after reset: bank 0 takes an odd tag and bank 1 an even
  // one, which neither bank can ever expect.
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == ADDR_W'(PIX_COUNT - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // Bank 0 write port.
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      bank0_mem[clr_addr_q] <= '{tag: TAG_W'(1), pos: 1'b0};
    end else if (wr_i.we && !wr_i.bank) begin
      bank0_mem[wr_i.addr] <= wr_i.entry;
    end
  end

  // Bank 1 write port.
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      bank1_mem[clr_addr_q] <= '{tag: TAG_W'(0), pos: 1'b0};
    end else if (wr_i.we && wr_i.bank) begin
      bank1_mem[wr_i.addr] <= wr_i.entry;
    end
  end

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_i.re) begin
      if (rd_i.bank) begin
        rdata_q <= bank1_mem[rd_i.addr];
      end else begin
        rdata_q <= bank0_mem[rd_i.addr];
      end
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_busy_q;

endmodule

// ===== rtl/etwfa_ctrl.sv =====
module etwfa_ctrl
  import etwfa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [22:0]          cfg_data_i,
  input  logic                 step_i,
  input  op_e                  op_i,
  input  logic [63:0]          stamp_i,
  output close_info_t          close_o,
  output logic [31:0]          window_number_o
);

  logic [SIZE_US_W-1:0] size_us_q, size_us_d;
  logic [22:0]          max_events_q, max_events_d;
  logic                 started_q, started_d;
  logic [63:0]          start_q, start_d;
  logic [31:0]          number_q, number_d;
  logic [22:0]          tally_q, tally_d;
  logic [63:0]          last_q, last_d;
  logic [63:0]          end_sum;
  logic [63:0]          force_end;
  close_info_t          info;

  // Window length in microseconds is worked out once on each write of the window size.
  always_comb begin
    size_us_d    = size_us_q;
    max_events_d = max_events_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WINDOW_SIZE: size_us_d = SIZE_US_W'(cfg_data_i[15:0]) * SIZE_US_W'(US_PER_MS);
        CFG_MAX_EVENTS:  max_events_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  assign end_sum = start_q + 64'(size_us_q);

  // End reported by a forced close.
  always_comb begin
    if (tally_q != '0) begin
      force_end = last_q;
    end else if (started_q) begin
      force_end = end_sum;
    end else begin
      force_end = '0;
    end
  end

  // Close decision and report for the item at the input.
  always_comb begin
    info          = '0;
    info.id       = number_q;
    info.start_us = start_q;
    info.events   = tally_q;
    unique case (op_i)
      OP_TICK: begin
        info.closed = started_q && (stamp_i >= end_sum);
        info.end_us = end_sum;
      end
      OP_FORCE: begin
        info.closed = 1'b1;
        info.end_us = force_end;
      end
      default: info.closed = 1'b0;
    endcase
    if (!info.closed) begin
      info = '0;
    end
  end

  // Window state update.
  always_comb begin
    started_d = started_q;
    start_d   = start_q;
    number_d  = number_q;
    tally_d   = tally_q;
    last_d    = last_q;
    if (step_i) begin
      if (info.closed) begin
        started_d = 1'b1;
        start_d   = info.end_us;
        number_d  = number_q + 1'b1;
        tally_d   = '0;
        last_d    = '0;
      end else if (op_i == OP_EVENT) begin
        if (!started_q) begin
          started_d = 1'b1;
          start_d   = stamp_i;
        end
        if (tally_q < max_events_q) begin
          tally_d = tally_q + 1'b1;
          last_d  = stamp_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_us_q    <= SIZE_US_W'(WINDOW_MS_RESET) * SIZE_US_W'(US_PER_MS);
      max_events_q <= MAX_EVENTS_RESET;
      started_q    <= 1'b0;
      start_q      <= '0;
      number_q     <= '0;
      tally_q      <= '0;
      last_q       <= '0;
    end else begin
      size_us_q    <= size_us_d;
      max_events_q <= max_events_d;
      started_q    <= started_d;
      start_q      <= start_d;
      number_q     <= number_d;
      tally_q      <= tally_d;
      last_q       <= last_d;
    end
  end

  assign close_o         = info;
  assign window_number_o = number_q;

endmodule

// ===== rtl/event_time_window_frame_accumulator.sv =====
// Paints event-camera events into a 768 x 608 frame store and closes time
// windows on tick or force items; each item gives exactly one result. The
// block takes one item per cycle while it is not stalled. An item's result
// is held first in one stage, while its pixel read completes, and then in
// one output register, from which it is offered. Apart from the clearing
// pass, the input stalls only while both are full and the result is not
// taken. Each item needs at most one access to each frame bank, which is
// what allows that rate. Live and closed frames share two banks picked by
// the parity of the window id, and each pixel carries the id it was painted
// in, so a close needs no copy or clear of the frame. After reset a clearing
// pass over every pixel of both banks runs before the first item is taken;
// configuration writes are taken throughout.
module event_time_window_frame_accumulator
  import etwfa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [22:0]          cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // stamp_us[63:0], pixel_x[73:64], pixel_y[83:74], positive[84], zero fill
  input  logic [87:0]          s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // window_closed[0], closed_id[32:1], closed_start_us[96:33],
  // closed_end_us[160:97], closed_events[183:161], pixel_value[191:184]
  output logic [191:0]         m_axis_tdata
);

  op_e               op;
  logic [63:0]       stamp;
  logic [9:0]        px;
  logic [9:0]        py;
  logic              pos;
  logic              in_frame;
  logic [ADDR_W-1:0] pix_addr;
  logic              accept;
  logic              busy;
  logic [31:0]       number;
  close_info_t       info;
  pix_wr_t           wr;
  pix_rd_t           rd;
  pix_entry_t        rdata;

  logic              s1_valid_q, s1_valid_d;
  close_info_t       s1_info_q;
  logic              s1_rd_q;
  logic [TAG_W-1:0]  s1_tag_q;
  logic              s1_move;
  logic [7:0]        pixel;
  logic              out_valid_q, out_valid_d;
  logic [191:0]      out_data_q;

  assign op    = op_e'(s_axis_tuser);
  assign stamp = s_axis_tdata[63:0];
  assign px    = s_axis_tdata[73:64];
  assign py    = s_axis_tdata[83:74];
  assign pos   = s_axis_tdata[84];

  assign in_frame = ({1'b0, px} < 11'(FRAME_WIDTH)) && ({1'b0, py} < 11'(FRAME_HEIGHT));
  assign pix_addr = ADDR_W'(ADDR_W'(py) * ADDR_W'(FRAME_WIDTH)) + ADDR_W'(px);

  // Handshake: the first stage moves on whenever the output register is free or its result is being taken.
  assign s1_move       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !busy && (!s1_valid_q || s1_move);
  assign accept        = s_axis_tvalid && s_axis_tready;

  etwfa_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .step_i          (accept),
    .op_i            (op),
    .stamp_i         (stamp),
    .close_o         (info),
    .window_number_o (number)
  );

  // Events go to the live bank, reads to the bank of the last closed window.
  always_comb begin
    wr.we        = accept && (op == OP_EVENT) && in_frame;
    wr.bank      = number[0];
    wr.addr      = pix_addr;
    wr.entry.tag = number;
    wr.entry.pos = pos;
    rd.re        = accept && (op == OP_READ);
    rd.bank      = ~number[0];
    rd.addr      = pix_addr;
  end

  etwfa_frame_mem u_mem (
    .clk_i,
    .rst_ni,
    .wr_i    (wr),
    .rd_i    (rd),
    .rdata_o (rdata),
    .busy_o  (busy)
  );

  // First stage holds the item while the pixel read completes.
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_info_q <= info;
      s1_rd_q   <= (op == OP_READ) && in_frame;
      s1_tag_q  <= number - 1'b1;
    end
  end

  // A pixel counts only if it was painted in the window that closed last.
  always_comb begin
    pixel = PIX_EMPTY;
    if (s1_rd_q && (rdata.tag == s1_tag_q)) begin
      pixel = rdata.pos ? PIX_POS : PIX_NEG;
    end
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_data_q <= {pixel, s1_info_q.events, s1_info_q.end_us, s1_info_q.start_us,
                     s1_info_q.id, s1_info_q.closed};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/etwfa_checker.sv =====
module etwfa_checker
  import etwfa_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [191:0] m_axis_tdata
);

  // A stalled result keeps its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Without a close, the close report fields are zero.
  a_open_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> (m_axis_tdata[183:1] == '0))
    else $error("close fields set without a close");

  // A close never carries a pixel.
  a_close_nopix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> (m_axis_tdata[191:184] == PIX_EMPTY))
    else $error("pixel value on a close");

  // Pixels are empty, negative or positive.
  a_pix_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[191:184] == PIX_EMPTY) ||
                      (m_axis_tdata[191:184] == PIX_NEG) ||
                      (m_axis_tdata[191:184] == PIX_POS))
    else $error("bad pixel code");

endmodule

bind event_time_window_frame_accumulator etwfa_checker u_etwfa_checker (
  .clk_i,
  .rst_ni,
  .m_axis_tvalid,
  .m_axis_tready,
  .m_axis_tdata
);
